/* sv/clt_pkg.sv */
package clt_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 262144;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CLASS_W     = 4;
   localparam int INDEX_W     = 18;

   localparam logic [CLASS_W-1:0] NO_COLOR_CLASS = 4'd8;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_PIXEL = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic {
      FILL_IDLE = 1'b0,
      FILL_RUN  = 1'b1
   } fill_state_type;

   // Table write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CLASS_W-1:0] data;
   } wr_type;

   // External class code to internal class
   function automatic logic [CLASS_W-1:0] map_code(input logic [7:0] code);
      logic [CLASS_W-1:0] cls;
      case (code)
         8'd1:    cls = 4'd0;
         8'd2:    cls = 4'd1;
         8'd3:    cls = 4'd2;
         8'd7:    cls = 4'd3;
         8'd9:    cls = 4'd4;
         8'd5:    cls = 4'd5;
         8'd6:    cls = 4'd6;
         8'd10:   cls = 4'd7;
         8'd11:   cls = 4'd9;
         default: cls = NO_COLOR_CLASS;
      endcase
      return cls;
   endfunction

   // Gray level per class: (class+1)*32 for 0..6, else zero
   function automatic logic [7:0] gray_of_class(input logic [CLASS_W-1:0] cls);
      logic [7:0] gray;
      case (cls)
         4'd0:    gray = 8'(1 << 5);
         4'd1:    gray = 8'(2 << 5);
         4'd2:    gray = 8'(3 << 5);
         4'd3:    gray = 8'(4 << 5);
         4'd4:    gray = 8'(5 << 5);
         4'd5:    gray = 8'(6 << 5);
         4'd6:    gray = 8'(7 << 5);
         4'd7:    gray = 8'(0 << 5);
         default: gray = 8'd0;
      endcase
      return gray;
   endfunction

endpackage

/* sv/clt_table_ram.sv */
module clt_table_ram (
   input  logic                        clock,
   input  clt_pkg::wr_type             wr,
   input  logic                        rd_en,
   input  logic [clt_pkg::ADDR_W-1:0]  rd_addr,
   output logic [clt_pkg::CLASS_W-1:0] rd_data
);
   import clt_pkg::*;

   logic [CLASS_W-1:0] mem [TABLE_DEPTH];
   logic [CLASS_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/rle_loaded_color_table_classifier.sv */
// Pixel, begin-load, no-op and non-filling run commands: result strobe passes the read and response stages.
// Run records: busy while the clipped run is written, then the result passes the read and response stages.
// Throughput: one pixel per cycle while not busy filling; run fill is one table entry per cycle (RAM write port).
// Reset (synchronous) clears fill position, full flag, FSM and result pipeline valid bits.
// Table contents are not swept: entries at or above the fill position read as no-color.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rle_loaded_color_table_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_run_length,
   input  logic [7:0]  req_run_code,
   input  logic [7:0]  req_first_channel,
   input  logic [7:0]  req_second_channel,
   input  logic [7:0]  req_third_channel,
   output logic        rsp_valid,
   output logic [7:0]  rsp_class_gray,
   output logic [3:0]  rsp_pixel_class,
   output logic [18:0] rsp_fill_position,
   output logic        rsp_table_full
);
   import clt_pkg::*;

   fill_state_type     state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               full_ff, full_in;
   logic [PTR_W-1:0]   remain_ff, remain_in;
   logic [CLASS_W-1:0] run_class_ff, run_class_in;

   // Read stage
   logic               a_valid_ff, a_valid_in;
   logic               a_pixel_ff, a_pixel_in;
   logic               a_hit_ff, a_hit_in;
   logic [PTR_W-1:0]   a_fill_ff, a_fill_in;
   logic               a_full_ff, a_full_in;

   // Response stage
   logic               rsp_valid_ff;
   logic [7:0]         rsp_gray_ff;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic [PTR_W-1:0]   rsp_fill_ff;
   logic               rsp_full_ff;

   logic               accept;
   cmd_type            cmd;
   logic [INDEX_W-1:0] pix_index;
   logic [PTR_W-1:0]   room;
   logic [PTR_W-1:0]   run_count;
   logic               can_fill;
   logic               last_write;
   logic [PTR_W-1:0]   ptr_next;
   wr_type             wr;
   logic [CLASS_W-1:0] rd_data;
   logic [CLASS_W-1:0] pix_class;

   assign accept    = start && !busy;
   assign cmd       = cmd_type'(req_command);
   assign pix_index = {req_first_channel[7:2], req_second_channel[7:2],
                       req_third_channel[7:2]};

   // Clip run against remaining room
   assign room      = PTR_W'(TABLE_DEPTH) - ptr_ff;
   assign run_count = (req_run_length < 32'(room)) ? PTR_W'(req_run_length) : room;
   assign can_fill  = !full_ff && (ptr_ff < PTR_W'(TABLE_DEPTH))
                      && (req_run_length != 32'd0);
   assign last_write = (state_ff == FILL_RUN) && (remain_ff == PTR_W'(1));
   assign ptr_next  = ptr_ff + PTR_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FILL_IDLE: begin
            if (accept && cmd == CMD_RUN && can_fill) begin
               state_in = FILL_RUN;
            end
         end
         FILL_RUN: begin
            if (remain_ff == PTR_W'(1)) begin
               state_in = FILL_IDLE;
            end
         end
         default: state_in = FILL_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      busy    = 1'b0;
      wr.en   = 1'b0;
      wr.addr = ptr_ff[ADDR_W-1:0];
      wr.data = run_class_ff;
      case (state_ff)
         FILL_IDLE: begin
            busy  = 1'b0;
            wr.en = 1'b0;
         end
         FILL_RUN: begin
            busy  = 1'b1;
            wr.en = 1'b1;
         end
         default: begin
            busy  = 1'b0;
            wr.en = 1'b0;
         end
      endcase
   end

   // Fill pointer, full flag and run counter
   always_comb begin
      ptr_in       = ptr_ff;
      full_in      = full_ff;
      remain_in    = remain_ff;
      run_class_in = run_class_ff;
      if (state_ff == FILL_RUN) begin
         ptr_in    = ptr_next;
         remain_in = remain_ff - PTR_W'(1);
         if (ptr_next == PTR_W'(TABLE_DEPTH)) begin
            full_in = 1'b1;
         end
      end else if (accept) begin
         case (cmd)
            CMD_LOAD: begin
               ptr_in  = '0;
               full_in = 1'b0;
            end
            CMD_RUN: begin
               remain_in    = run_count;
               run_class_in = map_code(req_run_code);
            end
            default: ;
         endcase
      end
   end

   // Read stage loads on a transfer that does not start a fill, or on fill end
   always_comb begin
      a_valid_in = 1'b0;
      a_pixel_in = 1'b0;
      a_hit_in   = 1'b0;
      a_fill_in  = ptr_in;
      a_full_in  = full_in;
      if (last_write) begin
         a_valid_in = 1'b1;
      end else if (accept && !(cmd == CMD_RUN && can_fill)) begin
         a_valid_in = 1'b1;
         a_pixel_in = (cmd == CMD_PIXEL);
         a_hit_in   = 32'(pix_index) < 32'(ptr_ff);
      end
   end

   // Entries below the fill position hold runs; the rest read as no-color
   assign pix_class = a_hit_ff ? rd_data : NO_COLOR_CLASS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FILL_IDLE;
         ptr_ff       <= '0;
         full_ff      <= 1'b0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         full_ff      <= full_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= a_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      remain_ff    <= remain_in;
      run_class_ff <= run_class_in;
      a_pixel_ff   <= a_pixel_in;
      a_hit_ff     <= a_hit_in;
      a_fill_ff    <= a_fill_in;
      a_full_ff    <= a_full_in;
      rsp_class_ff <= a_pixel_ff ? pix_class : '0;
      rsp_gray_ff  <= a_pixel_ff ? gray_of_class(pix_class) : 8'd0;
      rsp_fill_ff  <= a_fill_ff;
      rsp_full_ff  <= a_full_ff;
   end

   clt_table_ram u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (accept && cmd == CMD_PIXEL),
      .rd_addr (ADDR_W'(pix_index)),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_gray    = rsp_gray_ff;
   assign rsp_pixel_class   = rsp_class_ff;
   assign rsp_fill_position = 19'(rsp_fill_ff);
   assign rsp_table_full    = rsp_full_ff;

endmodule
